// ===== sv/dcf_pkg.sv =====
// Package: constants, types and helpers for the duplicate-rejecting code queue.
package dcf_pkg;
  localparam int DEPTH      = 16;
  localparam int CODE_CHARS = 10;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CODE_W     = 80;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_LIST   = 2'd2;
  localparam logic [1:0] FUNC_BAD    = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  // Command handed from front to back
  typedef struct packed {
    logic [1:0]        func;
    logic [CODE_W-1:0] code;
  } cmd_t;

  // Cut at first zero byte and at CODE_CHARS, fold a-z to upper case
  function automatic logic [CODE_W-1:0] normalise(input logic [CODE_W-1:0] raw);
    logic [CODE_W-1:0] r;
    logic              ended;
    logic [7:0]        b;
    r = '0;
    ended = 1'b0;
    for (int i = 0; i < 10; i++) begin
      b = raw[8*i +: 8];
      if (i >= CODE_CHARS || ended || b == 8'h00) begin
        ended = 1'b1;
        b = 8'h00;
      end else if (b >= 8'h61 && b <= 8'h7a) begin
        b = b - 8'h20;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction
endpackage

// ===== sv/dcf_if.sv =====
// Interfaces: input and result channels with valid/ready handshake.
interface dcf_in_if import dcf_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] code_low;
  logic [15:0] code_high;
  modport source (output valid, func, code_low, code_high, input ready);
  modport sink   (input valid, func, code_low, code_high, output ready);
endinterface

interface dcf_out_if import dcf_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] entry_low;
  logic [15:0] entry_high;
  logic        last;
  modport source (output valid, status, entry_low, entry_high, last, input ready);
  modport sink   (input valid, status, entry_low, entry_high, last, output ready);
endinterface

// ===== sv/dcf_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module dcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/dcf_front.sv =====
// Front end: accepts input beats, normalises codes, feeds a two-entry command queue.
module dcf_front import dcf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  dcf_in_if.sink in_ch,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_take
);
  cmd_t       q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic       push;

  assign in_ch.ready = (fill != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (fill != 2'd0);
  assign cmd         = q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].func <= in_ch.func;
      q[wr_ptr].code <= normalise({in_ch.code_high, in_ch.code_low});
    end
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_take) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(cmd_take);
    end
  end
endmodule

// ===== sv/dcf_back.sv =====
// Back end: carries out insert, remove and list against the entry RAM.
module dcf_back import dcf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  input  cmd_t     cmd,
  output logic     cmd_take,
  dcf_out_if.source out_ch
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;

  logic [1:0]        state, state_next;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr, ptr_next;  // offset of the entry under examination
  logic              dv;             // rdata holds the entry at ptr
  logic [CODE_W-1:0] rdata;
  logic [IDX_W-1:0]  raddr;
  logic              we;
  logic              step;
  logic              at_end;
  logic              hit;

  // Result to load this cycle
  logic              emit;
  logic [2:0]        res_status;
  logic [CODE_W-1:0] res_entry;
  logic              res_last;

  // Result register
  logic              ovalid;
  logic [2:0]        ostatus;
  logic [CODE_W-1:0] oentry;
  logic              olast;
  logic              ofree;

  assign out_ch.valid      = ovalid;
  assign out_ch.status     = ostatus;
  assign out_ch.entry_low  = oentry[63:0];
  assign out_ch.entry_high = oentry[79:64];
  assign out_ch.last       = olast;

  assign ofree  = !ovalid || out_ch.ready;
  assign at_end = (ptr == count);
  assign hit    = (rdata == cmd.code);

  // Read address follows the next offset so data for ptr is ready each cycle
  always_comb begin
    priority if (state != S_SCAN || cmd_take) ptr_next = '0;
    else if (step) ptr_next = CNT_W'(ptr + 1'b1);
    else ptr_next = ptr;
  end

  assign raddr = IDX_W'(head + ptr_next[IDX_W-1:0]);

  dcf_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (IDX_W'(head + count[IDX_W-1:0])),
    .wdata (cmd.code),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer: a scan looks at one entry a cycle; list waits on the result register
  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    we         = 1'b0;
    step       = 1'b0;
    emit       = 1'b0;
    res_status = ST_OK;
    res_entry  = '0;
    res_last   = 1'b1;
    unique case (state)
      S_IDLE: if (cmd_valid) state_next = S_SCAN;
      S_SCAN: begin
        unique case (cmd.func)
          FUNC_INSERT: begin
            if (at_end) begin
              if (ofree) begin
                cmd_take   = 1'b1;
                emit       = 1'b1;
                we         = (count != CNT_W'(DEPTH));
                res_status = (count == CNT_W'(DEPTH)) ? ST_FULL : ST_OK;
              end
            end else if (dv) begin
              if (hit) begin
                if (ofree) begin
                  cmd_take   = 1'b1;
                  emit       = 1'b1;
                  res_status = ST_DUP;
                end
              end else begin
                step = 1'b1;
              end
            end
          end
          FUNC_LIST: begin
            if (count == '0) begin
              if (ofree) begin
                cmd_take   = 1'b1;
                emit       = 1'b1;
                res_status = ST_EMPTY;
              end
            end else if (dv && ofree) begin
              emit      = 1'b1;
              step      = 1'b1;
              res_entry = rdata;
              res_last  = (CNT_W'(ptr + 1'b1) == count);
              cmd_take  = res_last;
            end
          end
          FUNC_REMOVE: begin
            if (ofree) begin
              cmd_take   = 1'b1;
              emit       = 1'b1;
              res_status = (count == '0) ? ST_EMPTY : ST_OK;
            end
          end
          FUNC_BAD: begin
            if (ofree) begin
              cmd_take   = 1'b1;
              emit       = 1'b1;
              res_status = ST_INVALID;
            end
          end
        endcase
        if (cmd_take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      count  <= '0;
      ptr    <= '0;
      dv     <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      dv    <= (state == S_SCAN) && !cmd_take;
      if (cmd_take && cmd.func == FUNC_REMOVE && count != '0) begin
        head  <= IDX_W'(head + 1'b1);
        count <= count - 1'b1;
      end
      if (we) count <= count + 1'b1;
      if (emit) ovalid <= 1'b1;
      else if (out_ch.ready) ovalid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      ostatus <= res_status;
      oentry  <= res_entry;
      olast   <= res_last;
    end
  end
endmodule

// ===== sv/dedup_code_fifo_top.sv =====
// Top level: duplicate-rejecting queue of codes, front end, command queue and back end.
//
//  channel  dir  payload                                   beat when
//  in_ch    in   func, code_low, code_high                 valid && ready
//  out_ch   out  status, entry_low, entry_high, last       valid && ready
//
// Insert scans the stored entries through the RAM read port, one per cycle.
// List gives one beat per entry at one per cycle when the sink keeps ready
// high. Remove and invalid need no RAM scan.
// Reset is synchronous; the queue is empty afterwards, RAM contents undefined.
// A stalled result sink holds the back end; the front keeps taking up to two beats.
module dedup_code_fifo_top import dcf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dcf_in_if.sink     in_ch,
  dcf_out_if.source  out_ch
);
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  dcf_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  dcf_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .out_ch(out_ch)
  );
endmodule

// ===== tb/dcf_check.sv =====
// Checker: watches both channels, models the code queue and compares result beats.
module dcf_check import dcf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dcf_in_if.source  in_mon,
  dcf_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending,
  output int        result_count,
  output int        dup_count,
  output int        full_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry_low;
    logic [15:0] entry_high;
    logic        last;
  } beat_t;

  logic [CODE_W-1:0] model_store [DEPTH];
  int                model_head;
  int                model_count;
  beat_t             expected_beats [$];

  // Fold a raw code: stop at first zero byte, cut at CODE_CHARS, upper-case a-z
  function automatic logic [CODE_W-1:0] fold_code(input logic [CODE_W-1:0] raw);
    logic [CODE_W-1:0] r;
    logic              done;
    logic [7:0]        b;
    r = '0;
    done = 1'b0;
    for (int i = 0; i < 10; i++) begin
      b = raw[8*i +: 8];
      if (i >= CODE_CHARS || done || b == 8'h00) begin
        done = 1'b1;
        b = 8'h00;
      end else if (b inside {[8'h61:8'h7a]}) begin
        b = b ^ 8'h20;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

  function automatic beat_t mk(input logic [2:0] st, input logic [CODE_W-1:0] e,
                               input logic lst);
    beat_t t;
    t.status = st;
    t.entry_low = e[63:0];
    t.entry_high = e[79:64];
    t.last = lst;
    return t;
  endfunction

  // Apply one command to the model and queue its result beats
  task automatic queue_results(input logic [1:0] f, input logic [CODE_W-1:0] raw);
    logic [CODE_W-1:0] c;
    logic              hit;
    c = fold_code(raw);
    hit = 1'b0;
    case (f)
      FUNC_INSERT: begin
        for (int i = 0; i < model_count; i++)
          if (model_store[(model_head + i) % DEPTH] == c) hit = 1'b1;
        if (hit) begin
          expected_beats.push_back(mk(ST_DUP, '0, 1'b1));
          dup_count++;
        end else if (model_count >= DEPTH) begin
          expected_beats.push_back(mk(ST_FULL, '0, 1'b1));
          full_count++;
        end else begin
          model_store[(model_head + model_count) % DEPTH] = c;
          model_count++;
          expected_beats.push_back(mk(ST_OK, '0, 1'b1));
        end
      end
      FUNC_REMOVE: begin
        if (model_count == 0) begin
          expected_beats.push_back(mk(ST_EMPTY, '0, 1'b1));
        end else begin
          model_head = (model_head + 1) % DEPTH;
          model_count--;
          expected_beats.push_back(mk(ST_OK, '0, 1'b1));
        end
      end
      FUNC_LIST: begin
        if (model_count == 0)
          expected_beats.push_back(mk(ST_EMPTY, '0, 1'b1));
        for (int i = 0; i < model_count; i++)
          expected_beats.push_back(mk(ST_OK, model_store[(model_head + i) % DEPTH],
                                      i + 1 == model_count));
      end
      default: expected_beats.push_back(mk(ST_INVALID, '0, 1'b1));
    endcase
  endtask

  // Sample both channels at each rising edge
  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      model_head = 0;
      model_count = 0;
      expected_beats.delete();
      fail_count = 0;
      result_count = 0;
      dup_count = 0;
      full_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            fail_count++;
          end
          if (out_mon.entry_low !== want.entry_low) begin
            $error("entry_low: expected %h, got %h", want.entry_low, out_mon.entry_low);
            fail_count++;
          end
          if (out_mon.entry_high !== want.entry_high) begin
            $error("entry_high: expected %h, got %h", want.entry_high,
                   out_mon.entry_high);
            fail_count++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_mon.last);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        queue_results(in_mon.func, {in_mon.code_high, in_mon.code_low});
    end
    pending = expected_beats.size();
  end
endmodule

// ===== tb/dedup_code_fifo_top_tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the code queue.
module dedup_code_fifo_top_tb import dcf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, result_count, dup_count, full_count;
  bit   calm = 1'b0;
  bit   hold_off = 1'b0;
  int   sent;

  dcf_in_if  in_ch ();
  dcf_out_if out_ch ();

  dedup_code_fifo_top dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  dcf_check u_check (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
                     .fail_count(fail_count), .pending(pending),
                     .result_count(result_count), .dup_count(dup_count),
                     .full_count(full_count));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Small pool of codes so duplicates and a full queue happen often
  logic [79:0] code_pool [24];

  function automatic logic [79:0] rand_code();
    logic [79:0] c;
    for (int i = 0; i < 10; i++)
      c[8*i +: 8] = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(8'h41, 8'h7a));
    if ($urandom_range(0, 3) == 0) c[8*$urandom_range(0, 9) +: 8] = 8'h00;
    return c;
  endfunction

  // Offer one beat and wait for it to be taken, with random gaps before
  task automatic send_cmd(input logic [1:0] f, input logic [79:0] c);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.code_low  <= c[63:0];
    in_ch.code_high <= c[79:64];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Result sink: random stall bursts, plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else out_ch.ready <= 1'b1;
    end
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [79:0] c;
    int          f;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_INSERT;
    in_ch.code_low = '0;
    in_ch.code_high = '0;
    sent = 0;
    foreach (code_pool[i]) code_pool[i] = rand_code();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cases, extremes, folding, cut at zero, invalid
    send_cmd(FUNC_REMOVE, '0);
    send_cmd(FUNC_LIST, '0);
    send_cmd(FUNC_BAD, '1);
    send_cmd(FUNC_INSERT, '0);
    send_cmd(FUNC_INSERT, {16'h0000, 64'h0000_0000_0000_0041});
    send_cmd(FUNC_INSERT, '1);
    send_cmd(FUNC_INSERT, '1);
    send_cmd(FUNC_INSERT, {16'h7a61, 64'h7a61_7a61_7a61_7a61});
    send_cmd(FUNC_INSERT, {16'h5a41, 64'h5a41_5a41_5a41_5a41});
    send_cmd(FUNC_INSERT, {16'hffff, 64'hffff_ff00_6162_6364});
    send_cmd(FUNC_INSERT, {16'h0000, 64'h0000_0000_4142_4344});
    send_cmd(FUNC_INSERT, {16'h6040, 64'h7b5b_80ff_1f20_7f01});
    send_cmd(FUNC_LIST, '0);
    // Fill to full, then a full list
    for (int i = 0; i < 12; i++) send_cmd(FUNC_INSERT, {16'h0001, 64'(i + 1000)});
    send_cmd(FUNC_LIST, '0);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);

    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_cmd(FUNC_LIST, '0);
    join

    // Random part: mostly inserts and removes over a small pool
    for (int n = 0; n < 350; n++) begin
      if (n > 300) calm = 1'b1;
      f = $urandom_range(0, 19);
      c = $urandom_range(0, 4) == 0 ? rand_code() : code_pool[$urandom_range(0, 23)];
      if (f < 9)       send_cmd(FUNC_INSERT, c);
      else if (f < 15) send_cmd(FUNC_REMOVE, c);
      else if (f < 19) send_cmd(FUNC_LIST, c);
      else             send_cmd(FUNC_BAD, c);
    end
    in_ch.valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d commands, checked %0d result beats (%0d duplicate, %0d full).",
             sent, result_count, dup_count, full_count);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// ===== dedup_code_fifo_top.f =====
sv/dcf_pkg.sv
sv/dcf_if.sv
sv/dcf_ram.sv
sv/dcf_front.sv
sv/dcf_back.sv
sv/dedup_code_fifo_top.sv
tb/dcf_check.sv
tb/dedup_code_fifo_top_tb.sv
